### src/dsrc_pkg.sv
// Shared types and constants for the density shaded region color block.
package dsrc_pkg;

  localparam int unsigned POP_W = 24;
  localparam int unsigned AREA_W = 40;
  localparam int unsigned CH_W = 8;
  localparam int unsigned REG_W = 32;
  localparam int unsigned IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_SHADING_ON = 2'd0;
  localparam logic [IDX_W-1:0] REG_DENSITY_LOW = 2'd1;
  localparam logic [IDX_W-1:0] REG_DENSITY_SPAN = 2'd2;

  localparam logic [REG_W-1:0] SPAN_RESET = 32'h0400_0000;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [9:0] FULL_WEIGHT = 10'd765;

  // Base color carried down the pipe.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } color_t;

endpackage

### src/dsrc_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
module dsrc_divider #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 40,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] side_out
);
  localparam int unsigned R_W = DEN_W + 1;

  logic [NUM_W:0]    vld;
  logic [NUM_W-1:0]  nm [NUM_W+1];
  logic [NUM_W-1:0]  qt [NUM_W+1];
  logic [R_W-1:0]    rm [NUM_W+1];
  logic [DEN_W-1:0]  dn [NUM_W+1];
  logic [SIDE_W-1:0] sd [NUM_W+1];

  always_comb begin
    vld[0] = in_valid;
    nm[0] = num;
    qt[0] = '0;
    rm[0] = '0;
    dn[0] = den;
    sd[0] = side_in;
  end

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [R_W-1:0] trial;
    logic [R_W:0] diff;
    assign trial = {rm[s][R_W-2:0], nm[s][NUM_W-1-s]};
    assign diff = {1'b0, trial} - {2'b00, dn[s]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nm[s+1] <= nm[s];
        dn[s+1] <= dn[s];
        sd[s+1] <= sd[s];
        if (!diff[R_W]) begin
          rm[s+1] <= diff[R_W-1:0];
          qt[s+1] <= qt[s] | (NUM_W'(1) << (NUM_W-1-s));
        end else begin
          rm[s+1] <= trial;
          qt[s+1] <= qt[s];
        end
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quot = qt[NUM_W];
  assign side_out = sd[NUM_W];
endmodule

### src/dsrc_log.sv
// Pipelined fixed point natural log: normalize, 32 squaring stages, scale.
module dsrc_log #(
  parameter int unsigned FRACTION_BITS = 26,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       x,
  input  logic              sat,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [31:0]       dens,
  output logic [SIDE_W-1:0] side_out
);
  import dsrc_pkg::*;

  localparam int unsigned SH = 32 - FRACTION_BITS;

  // normalize stage
  logic [5:0] e_c;
  logic [32:0] m_c;
  always_comb begin
    e_c = '0;
    for (int k = 0; k < 64; k++) begin
      if (x[k]) e_c = 6'(k);
    end
    if (e_c >= 6'd31) m_c = 33'(x >> (e_c - 6'd31));
    else m_c = 33'(x << (6'd31 - e_c));
  end

  logic [32:0] vld;
  logic [32:0] mm [33];
  logic [31:0] fr [33];
  logic [5:0]  ee [33];
  logic [32:0] st;
  logic [SIDE_W-1:0] sd [33];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mm[0] <= m_c;
      fr[0] <= '0;
      ee[0] <= e_c;
      st[0] <= sat;
      sd[0] <= side_in;
    end
  end

  for (genvar s = 0; s < 32; s++) begin : g_sq
    logic [65:0] p;
    logic [34:0] q;
    assign p = mm[s] * mm[s];
    assign q = p[65:31];
    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else if (en) vld[s+1] <= vld[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ee[s+1] <= ee[s];
        st[s+1] <= st[s];
        sd[s+1] <= sd[s];
        if (q[34:32] != 3'd0) begin
          mm[s+1] <= q[33:1];
          fr[s+1] <= {fr[s][30:0], 1'b1};
        end else begin
          mm[s+1] <= q[32:0];
          fr[s+1] <= {fr[s][30:0], 1'b0};
        end
      end
    end
  end

  // scale stage 1: products
  logic v1, st1;
  logic [63:0] fp1;
  logic [37:0] ip1;
  logic [SIDE_W-1:0] sd1;
  logic [5:0] ipart;
  assign ipart = ee[32] - 6'(FRACTION_BITS);
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= vld[32];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      fp1 <= fr[32] * LN2_Q32;
      ip1 <= ipart * LN2_Q32;
      st1 <= st[32];
      sd1 <= sd[32];
    end
  end

  // scale stage 2: sum, shift, saturate (ipart >= 0 since x >= 2^F)
  logic [38:0] lnq;
  logic [38:0] lns;
  assign lnq = {1'b0, ip1} + 39'(fp1[63:32]);
  assign lns = lnq >> SH;
  logic v2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dens <= (st1 || lns[38:32] != '0) ? 32'hFFFF_FFFF : lns[31:0];
      side_out <= sd1;
    end
  end
  assign out_valid = v2;
endmodule

### src/dsrc_blend.sv
// Grey mapping division and color blending stages.
module dsrc_blend #(
  parameter int unsigned SIDE_W = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       dens,
  input  logic [31:0]       low,
  input  logic [31:0]       span,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output dsrc_pkg::color_t  color,
  output logic [7:0]        grey
);
  import dsrc_pkg::*;

  // side: {shade, color}
  localparam int unsigned D_SIDE = SIDE_W + 2;

  logic below, zspan;
  logic [39:0] num;
  assign below = dens <= low;
  assign zspan = span == '0;
  assign num = 40'(dens - low) * 40'd255;

  logic dv;
  logic [39:0] dq;
  logic [D_SIDE-1:0] dside;

  logic v0;
  logic [39:0] num0;
  logic [31:0] sp0;
  logic [D_SIDE-1:0] side0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      num0 <= num;
      sp0 <= zspan ? 32'd1 : span;
      side0 <= {below, zspan, side_in};
    end
  end

  dsrc_divider #(.NUM_W(40), .DEN_W(32), .SIDE_W(D_SIDE)) u_gdiv (
    .clk, .rst, .en,
    .in_valid(v0), .num(num0), .den(sp0), .side_in(side0),
    .out_valid(dv), .quot(dq), .side_out(dside)
  );

  // grey and weights; a runs 0..128
  logic [7:0] g_c;
  logic [7:0] a_c;
  logic [7:0] g_bits;
  assign g_bits = (dq > 40'd255) ? 8'd255 : 8'(dq);
  always_comb begin
    if (dside[D_SIDE-1]) g_c = 8'd0;
    else if (dside[D_SIDE-2]) g_c = 8'd255;
    else g_c = g_bits;
    a_c = g_c[7] ? g_c - 8'd128 : 8'd128 - g_c;
  end

  logic v1, sh1;
  logic [7:0] g1;
  color_t c1;
  logic [14:0] ga1;
  logic [17:0] r1, gr1, b1;
  logic [9:0] w;
  assign w = FULL_WEIGHT - 10'(a_c);
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= dv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g1 <= g_c;
      sh1 <= dside[SIDE_W-1];
      c1 <= dside[23:0];
      ga1 <= 15'(g_c * a_c);
      r1 <= 18'(dside[23:16] * w);
      gr1 <= 18'(dside[15:8] * w);
      b1 <= 18'(dside[7:0] * w);
    end
  end

  // divide by 765 via reciprocal: floor(v*350897 >> 28) exact for v < 2^18
  function automatic logic [7:0] div765(input logic [17:0] v);
    logic [36:0] p;
    p = v * 37'd350897;
    return p[35:28];
  endfunction

  logic v2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (sh1) begin
        color.red <= div765(r1) + div765(18'(ga1));
        color.green <= div765(gr1) + div765(18'(ga1));
        color.blue <= div765(b1) + div765(18'(ga1));
        grey <= g1;
      end else begin
        color <= c1;
        grey <= '0;
      end
    end
  end
  assign out_valid = v2;
endmodule

### src/density_shaded_region_color_top.sv
// Top level of the density shaded region color block.
// Shades one region color per request by log population density.
// Input stream s_axis: population, area and base RGB in tdata; one request
// per cycle while s_axis_tready is high. Output stream m_axis: red, green,
// blue and grey level in tdata, one result per request, in order.
// Configuration: cfg_we writes register cfg_index (0 shading on, 1 density
// low, 2 density span) with cfg_data; write only while the pipe is empty.
// The pipe holds 64 stages of the quotient divider, 33 normalize and
// squaring stages and 2 scale stages of the log, 40 stages of the grey
// divider, 3 blend stages and the output stage.
// Throughput is one request per cycle. The whole pipe advances together;
// when m_axis_tready is low and the output register is full, the pipe
// holds and s_axis_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits and sets the registers to shading off,
// density low 0 and density span 1.0.
module density_shaded_region_color_top #(
  parameter int unsigned FRACTION_BITS = 26
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // population[23:0], region_area[63:24], red_in, green_in, blue_in
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // red_out[7:0], green_out, blue_out, grey_level[31:24]
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import dsrc_pkg::*;

  logic shading_on;
  logic [31:0] density_low, density_span;
  always_ff @(posedge clk) begin
    if (rst) begin
      shading_on <= 1'b0;
      density_low <= '0;
      density_span <= SPAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHADING_ON: shading_on <= cfg_data[0];
        REG_DENSITY_LOW: density_low <= cfg_data;
        REG_DENSITY_SPAN: density_span <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [23:0] pop;
  logic [39:0] area;
  color_t cin;
  assign pop = s_axis_tdata[23:0];
  assign area = s_axis_tdata[63:24];
  assign cin = {s_axis_tdata[71:64], s_axis_tdata[79:72], s_axis_tdata[87:80]};

  // side: {zero area, shade, color}
  localparam int unsigned S_W = 26;
  logic qv;
  logic [63:0] q;
  logic [S_W-1:0] qside;
  dsrc_divider #(.NUM_W(64), .DEN_W(40), .SIDE_W(S_W)) u_qdiv (
    .clk, .rst, .en,
    .in_valid(s_axis_tvalid && en),
    .num(64'(pop) << FRACTION_BITS),
    .den(area == '0 ? 40'd1 : area),
    .side_in({area == '0, shading_on, cin}),
    .out_valid(qv), .quot(q), .side_out(qside)
  );

  logic lv;
  logic [31:0] dens;
  logic [S_W-2:0] lside;
  dsrc_log #(.FRACTION_BITS(FRACTION_BITS), .SIDE_W(S_W-1)) u_log (
    .clk, .rst, .en,
    .in_valid(qv), .x(q + (64'd1 << FRACTION_BITS)), .sat(qside[S_W-1]),
    .side_in(qside[S_W-2:0]),
    .out_valid(lv), .dens(dens), .side_out(lside)
  );

  logic bv;
  color_t cout;
  logic [7:0] grey;
  dsrc_blend #(.SIDE_W(S_W-1)) u_blend (
    .clk, .rst, .en,
    .in_valid(lv), .dens(dens), .low(density_low), .span(density_span),
    .side_in(lside),
    .out_valid(bv), .color(cout), .grey(grey)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= bv;
  end
  always_ff @(posedge clk) begin
    if (en) m_axis_tdata <= {grey, cout.blue, cout.green, cout.red};
  end
endmodule
